@@ rtl/clfp_pkg.sv @@
// Package for the colon field line parser.
// Holds the character codes, the number phase type and the request struct.
// No dependencies.
package clfp_pkg;

  // Default line buffer size; only the first LINE_BUFFER_DEFAULT-1 characters count.
  localparam int unsigned LINE_BUFFER_DEFAULT = 32;

  // Number of value fields in one command.
  localparam int unsigned NUM_FIELDS = 4;

  // Width of the field count on the result side.
  localparam int unsigned FIELD_CNT_W = 3;

  // Character codes used by the parser.
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;

  // Progress through one numeric field.
  typedef enum logic [1:0] {
    PHASE_SKIP   = 2'd0,
    PHASE_DIGITS = 2'd1,
    PHASE_DONE   = 2'd2
  } phase_e;

  // One received character request moving from the input register to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_req_t;

  // Whitespace as accepted before the sign: space and tab through carriage return.
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // Decimal digit test.
  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

@@ rtl/clfp_in_reg.sv @@
// Input register of the colon field line parser.
// Captures one received byte request and holds it until the parser takes it.
// Depends on clfp_pkg.
module clfp_in_reg
  import clfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  output byte_req_t  req_o,
  input  logic       req_ready_i
);

  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;

  // The register can load when empty or when its content leaves this cycle.
  assign s_ready_o = !valid_q || req_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (s_ready_o) begin
      valid_d = s_valid_i;
      if (s_valid_i) begin
        data_d = s_data_i;
      end
    end
  end

  // Valid flag is control state and is reset; the byte is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign req_o.valid = valid_q;
  assign req_o.data  = data_q;

endmodule

@@ rtl/clfp_parser.sv @@
// Line parsing state and result register of the colon field line parser.
// Updates the running field state for each byte and loads a result on newline.
// Depends on clfp_pkg.
module clfp_parser
  import clfp_pkg::*;
#(
  parameter int unsigned LineBuffer = LINE_BUFFER_DEFAULT
)(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  byte_req_t              req_i,
  output logic                   req_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             led_address_o,
  output logic [7:0]             red_level_o,
  output logic [7:0]             green_level_o,
  output logic [7:0]             blue_level_o,
  output logic [FIELD_CNT_W-1:0] fields_found_o
);

  localparam int unsigned CntW = (LineBuffer > 2) ? $clog2(LineBuffer) : 1;
  localparam logic [CntW-1:0] CntLimit = CntW'(LineBuffer - 1);
  localparam logic [FIELD_CNT_W-1:0] FieldMax = FIELD_CNT_W'(NUM_FIELDS);

  // Running line state.
  logic [CntW-1:0]        char_count_q, char_count_d;
  logic                   content_ended_q, content_ended_d;
  logic [FIELD_CNT_W-1:0] field_index_q, field_index_d;
  logic                   inside_field_q, inside_field_d;
  phase_e                 phase_q, phase_d;
  logic                   is_negative_q, is_negative_d;
  logic [7:0]             accumulator_q, accumulator_d;
  logic [7:0]             field_values_q [NUM_FIELDS];
  logic [7:0]             field_values_d [NUM_FIELDS];

  // Result register.
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             res_values_q [NUM_FIELDS];
  logic [FIELD_CNT_W-1:0] res_count_q;

  logic       take;
  logic       is_newline;
  logic [7:0] c;

  assign c           = req_i.data;
  assign is_newline  = (c == CHAR_NEWLINE);
  assign req_ready_o = !out_valid_q || out_ready_i;
  assign take        = req_i.valid && req_ready_o;

  // Next state of the line parser for one accepted byte.
  always_comb begin
    logic [7:0]             acc0;
    logic                   neg0;
    logic [FIELD_CNT_W-1:0] fi0;
    phase_e                 ph0;
    logic                   store;
    logic [7:0]             store_val;
    logic [11:0]            acc_mul;
    logic [FIELD_CNT_W-1:0] slot;

    char_count_d    = char_count_q;
    content_ended_d = content_ended_q;
    field_index_d   = field_index_q;
    inside_field_d  = inside_field_q;
    phase_d         = phase_q;
    is_negative_d   = is_negative_q;
    accumulator_d   = accumulator_q;
    for (int i = 0; i < NUM_FIELDS; i++) begin
      field_values_d[i] = field_values_q[i];
    end
    acc0      = accumulator_q;
    neg0      = is_negative_q;
    fi0       = field_index_q;
    ph0       = phase_q;
    store     = 1'b0;
    store_val = 8'd0;
    acc_mul   = 12'd0;
    slot      = '0;

    if (take) begin
      if (is_newline) begin
        // End of line: start over for the next command.
        char_count_d    = '0;
        content_ended_d = 1'b0;
        field_index_d   = '0;
        inside_field_d  = 1'b0;
        phase_d         = PHASE_SKIP;
        is_negative_d   = 1'b0;
        accumulator_d   = 8'd0;
        for (int i = 0; i < NUM_FIELDS; i++) begin
          field_values_d[i] = 8'd0;
        end
      end else if (!content_ended_q && (char_count_q < CntLimit)) begin
        char_count_d = char_count_q + CntW'(1);
        if (c == CHAR_NUL) begin
          content_ended_d = 1'b1;
        end else if (c == CHAR_COLON) begin
          inside_field_d = 1'b0;
        end else begin
          // First character of a new field resets the number reader.
          if (!inside_field_q) begin
            acc0 = 8'd0;
            neg0 = 1'b0;
            if (field_index_q < FieldMax) begin
              fi0 = field_index_q + FIELD_CNT_W'(1);
              ph0 = PHASE_SKIP;
            end else begin
              ph0 = PHASE_DONE;
            end
          end
          inside_field_d = 1'b1;

          case (ph0)
            PHASE_SKIP: begin
              if (is_blank(c)) begin
                ph0 = PHASE_SKIP;
              end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
                neg0  = (c == CHAR_MINUS);
                ph0   = PHASE_DIGITS;
                store = 1'b1;
              end else if (is_digit(c)) begin
                acc_mul = {4'd0, acc0} * 12'd10 + {4'd0, c - CHAR_ZERO};
                acc0    = acc_mul[7:0];
                ph0     = PHASE_DIGITS;
                store   = 1'b1;
              end else begin
                ph0 = PHASE_DONE;
              end
            end
            PHASE_DIGITS: begin
              if (is_digit(c)) begin
                acc_mul = {4'd0, acc0} * 12'd10 + {4'd0, c - CHAR_ZERO};
                acc0    = acc_mul[7:0];
                store   = 1'b1;
              end else begin
                ph0 = PHASE_DONE;
              end
            end
            default: begin
              ph0 = PHASE_DONE;
            end
          endcase

          // The current field value is kept up to date after every digit or sign.
          store_val = neg0 ? (8'd0 - acc0) : acc0;
          slot      = fi0 - FIELD_CNT_W'(1);
          if (store && (fi0 != '0)) begin
            field_values_d[slot[1:0]] = store_val;
          end

          field_index_d = fi0;
          phase_d       = ph0;
          is_negative_d = neg0;
          accumulator_d = acc0;
        end
      end
    end
  end

  // Result handshake: a newline loads the register, the consumer drains it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take && is_newline) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q    <= '0;
      content_ended_q <= 1'b0;
      field_index_q   <= '0;
      inside_field_q  <= 1'b0;
      phase_q         <= PHASE_SKIP;
      is_negative_q   <= 1'b0;
      accumulator_q   <= 8'd0;
      out_valid_q     <= 1'b0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        field_values_q[i] <= 8'd0;
      end
    end else begin
      char_count_q    <= char_count_d;
      content_ended_q <= content_ended_d;
      field_index_q   <= field_index_d;
      inside_field_q  <= inside_field_d;
      phase_q         <= phase_d;
      is_negative_q   <= is_negative_d;
      accumulator_q   <= accumulator_d;
      out_valid_q     <= out_valid_d;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        field_values_q[i] <= field_values_d[i];
      end
    end
  end

  // Result payload is captured from the state as it stands before the newline.
  always_ff @(posedge clk_i) begin
    if (take && is_newline) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        res_values_q[i] <= field_values_q[i];
      end
      res_count_q <= field_index_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_address_o  = res_values_q[0];
  assign red_level_o    = res_values_q[1];
  assign green_level_o  = res_values_q[2];
  assign blue_level_o   = res_values_q[3];
  assign fields_found_o = res_count_q;

  // The field counter saturates at the number of fields.
  a_field_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_index_q <= FieldMax)
    else $error("field index beyond the field count");

  // The character counter never passes the line buffer limit.
  a_char_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_count_q <= CntLimit)
    else $error("character count beyond the line limit");

  // A newline taken by the parser clears the line state on the next cycle.
  a_newline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && is_newline) |=> (field_index_q == '0) && (char_count_q == '0)
                              && !content_ended_q && !inside_field_q)
    else $error("line state not cleared after newline");

  // A newline taken always presents a result on the next cycle.
  a_newline_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && is_newline) |=> out_valid_q)
    else $error("newline did not produce a result");

  // A pending result that is not taken stays in place.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(res_count_q))
    else $error("pending result lost while stalled");

endmodule

@@ rtl/colon_field_line_parser_top.sv @@
// Channel      Dir  Width  Contents
// s_axis       in   8      rx_byte [7:0]
// m_axis       out  40     led_address, red_level, green_level, blue_level, fields_found
//
// One byte per cycle is accepted while the result side is ready. A byte is held in the
// input register and is parsed on its way into the result register, so a newline's
// result appears in the cycle after the parser takes its request.
// Throughput is set by the single parsing stage.
// Reset clears all line state. A full, unread result register stops the parsing stage,
// and the input side stalls once the input register also holds a byte.
//
// Top level of the colon field line parser; depends on clfp_pkg, clfp_in_reg
// and clfp_parser.
module colon_field_line_parser_top
  import clfp_pkg::*;
#(
  parameter int unsigned LineBuffer = LINE_BUFFER_DEFAULT
)(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] led_address, [15:8] red_level, [23:16] green_level,
  // [31:24] blue_level, [34:32] fields_found, [39:35] zero
  output logic [39:0] m_axis_tdata
);

  byte_req_t              req;
  logic                   req_ready;
  logic [7:0]             led_address;
  logic [7:0]             red_level;
  logic [7:0]             green_level;
  logic [7:0]             blue_level;
  logic [FIELD_CNT_W-1:0] fields_found;

  // Input register.
  clfp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .req_o       (req),
    .req_ready_i (req_ready)
  );

  // Parsing stage and result register.
  clfp_parser #(
    .LineBuffer (LineBuffer)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .req_ready_o    (req_ready),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .led_address_o  (led_address),
    .red_level_o    (red_level),
    .green_level_o  (green_level),
    .blue_level_o   (blue_level),
    .fields_found_o (fields_found)
  );

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = {5'd0, fields_found, blue_level, green_level, red_level, led_address};

endmodule

@@ bench/colon_field_line_parser_top_tb.sv @@
// Self-checking testbench for colon_field_line_parser_top.
// Drives byte requests over the input stream and checks every parsed command against the
// bench's line parser model or a fixed row value. Depends on clfp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module colon_field_line_parser_top_tb;
  import clfp_pkg::*;

  localparam int unsigned LINE_BUF = LINE_BUFFER_DEFAULT;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DIR_ROWS = 12;
  localparam int RANDOM_BYTES = 600;
  localparam int CALM_BYTES = 120;
  // In the directed rows a tilde stands for a NUL byte.
  localparam byte NUL_MARK = "~";

  // One parsed command as it leaves the block, packed like m_axis_tdata.
  typedef struct packed {
    logic [4:0] pad;
    logic [2:0] fields_found;
    logic [7:0] blue_level;
    logic [7:0] green_level;
    logic [7:0] red_level;
    logic [7:0] led_address;
  } led_cmd_t;

  // One directed line; want is used only where fixed is set.
  typedef struct {
    string    text;
    bit       fixed;
    led_cmd_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  // Line state of the bench's parser model.
  logic [7:0] line_chars;
  logic       line_cut;
  logic [2:0] field_cnt;
  logic       in_field;
  phase_e     num_phase;
  logic       neg_sign;
  logic [7:0] digit_acc;
  logic [7:0] field_val [NUM_FIELDS];

  led_cmd_t    pending_cmds [$];
  led_cmd_t    fixed_cmds [int];
  int          lines_done = 0;
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          stuck_cycles = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_gaps_on = 1'b1;
  bit          long_hold_req = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{"\n", 1'b1, 40'h00_0000_0000},
    '{"255:255:255:255\n", 1'b1, 40'h04_FFFF_FFFF},
    '{"0:0:0:0\n", 1'b1, 40'h04_0000_0000},
    '{"::1:::2:3:4::\n", 1'b0, '0},
    '{" \t-1:+: \0137:-\n", 1'b0, '0},
    '{"1:2:3:4:5:6\n", 1'b0, '0},
    '{"12~:34\n", 1'b0, '0},
    '{"                             12:34:56\n", 1'b0, '0},
    '{"300:-1:-256:999\n", 1'b0, '0},
    '{"\377x:a5:\r\n", 1'b0, '0},
    '{":\n", 1'b0, '0},
    '{"7 8:-0:+12z:9\n", 1'b0, '0}
  };

  colon_field_line_parser_top #(
    .LineBuffer(LINE_BUF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Clears the model's line state, as after reset and after every newline.
  task automatic clear_line_state();
    line_chars = '0;
    line_cut   = 1'b0;
    field_cnt  = '0;
    in_field   = 1'b0;
    num_phase  = PHASE_SKIP;
    neg_sign   = 1'b0;
    digit_acc  = '0;
    foreach (field_val[i]) field_val[i] = '0;
  endtask

  // Stores the signed running value into the slot of the current field.
  task automatic latch_field();
    if (field_cnt != 0) begin
      field_val[2'(field_cnt - 3'd1)] = neg_sign ? 8'(8'd0 - digit_acc) : digit_acc;
    end
  endtask

  // Advances the model by one received byte; a newline yields a command.
  task automatic parse_char(input logic [7:0] c, output bit emits, output led_cmd_t cmd);
    bit sign_taken;
    emits = 1'b0;
    cmd = '0;
    sign_taken = 1'b0;
    if (c == CHAR_NEWLINE) begin
      emits = 1'b1;
      cmd.led_address  = field_val[0];
      cmd.red_level    = field_val[1];
      cmd.green_level  = field_val[2];
      cmd.blue_level   = field_val[3];
      cmd.fields_found = field_cnt;
      clear_line_state();
    end else if (!line_cut && int'(line_chars) < int'(LINE_BUF) - 1) begin
      line_chars++;
      if (c == CHAR_NUL) begin
        line_cut = 1'b1;
      end else if (c == CHAR_COLON) begin
        in_field = 1'b0;
      end else begin
        // The first character after a separator opens a new field.
        if (!in_field) begin
          in_field  = 1'b1;
          digit_acc = '0;
          neg_sign  = 1'b0;
          if (field_cnt < NUM_FIELDS) begin
            field_cnt++;
            num_phase = PHASE_SKIP;
          end else begin
            num_phase = PHASE_DONE;
          end
        end
        // Leading whitespace is skipped, then one optional sign is taken.
        if (num_phase == PHASE_SKIP) begin
          if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            neg_sign   = (c == CHAR_MINUS);
            num_phase  = PHASE_DIGITS;
            sign_taken = 1'b1;
            latch_field();
          end else if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
            num_phase = PHASE_DIGITS;
          end
        end
        // Digits accumulate modulo 256; anything else ends the number.
        if (num_phase == PHASE_DIGITS && !sign_taken) begin
          if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            digit_acc = digit_acc * 8'd10 + (c - CHAR_ZERO);
            latch_field();
          end else begin
            num_phase = PHASE_DONE;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Sends one byte request, after a random gap if gaps are on, and waits for acceptance.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (src_gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Sends one random line: mostly well-formed commands, some noise, long lines and NULs.
  task automatic send_random_line();
    logic [7:0]  txt [$];
    logic [7:0]  ws;
    int unsigned kind;
    int unsigned n_fields;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 40)) txt.push_back(8'($urandom));
    end else begin
      if (kind == 1) repeat ($urandom_range(20, 40)) txt.push_back(CHAR_SPACE);
      n_fields = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : NUM_FIELDS;
      if ($urandom_range(0, 7) == 0) txt.push_back(CHAR_COLON);
      for (int f = 0; f < int'(n_fields); f++) begin
        if (f != 0) begin
          repeat (($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1)
            txt.push_back(CHAR_COLON);
        end
        if ($urandom_range(0, 4) == 0) begin
          ws = 8'($urandom_range(CHAR_TAB, CHAR_CR));
          txt.push_back((ws == CHAR_NEWLINE) ? CHAR_SPACE : ws);
        end
        case ($urandom_range(0, 5))
          0: txt.push_back(CHAR_MINUS);
          1: txt.push_back(CHAR_PLUS);
          default: ;
        endcase
        repeat ($urandom_range(0, 4)) txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) txt.push_back(8'($urandom_range(33, 126)));
      end
    end
    if ($urandom_range(0, 19) == 0) txt.insert($urandom_range(0, txt.size()), CHAR_NUL);
    txt.push_back(CHAR_NEWLINE);
    foreach (txt[k]) send_byte(txt[k]);
  endtask

  // Result side ready: random stall bursts, plus one long hold on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (sink_gaps_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Feeds accepted byte requests to the model and checks accepted results.
  always @(posedge clk_i) begin : scoreboard
    bit       emits;
    led_cmd_t cmd;
    led_cmd_t want;
    led_cmd_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata, emits, cmd);
        if (emits) begin
          pending_cmds.push_back(fixed_cmds.exists(lines_done) ? fixed_cmds[lines_done] : cmd);
          lines_done++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_cmds.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("led_address", want.led_address, got.led_address);
          check_field("red_level", want.red_level, got.red_level);
          check_field("green_level", want.green_level, got.green_level);
          check_field("blue_level", want.blue_level, got.blue_level);
          check_field("fields_found", 8'(want.fields_found), 8'(got.fields_found));
          check_field("padding", 8'(want.pad), 8'(got.pad));
        end
      end
    end
  end

  // Ends the run when neither side has moved for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    clear_line_state();
    foreach (dir_rows[r]) begin
      if (dir_rows[r].fixed) fixed_cmds[r] = dir_rows[r].want;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines, one command each.
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].text.len(); k++) begin
        send_byte((dir_rows[r].text[k] == NUL_MARK) ? CHAR_NUL : dir_rows[r].text[k]);
      end
    end

    // Hold the result side off while short lines keep coming, so the input stalls.
    long_hold_req = 1'b1;
    repeat (12) begin
      send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
      send_byte(CHAR_NEWLINE);
    end

    // Pause the input until every expected command has come out.
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);

    // Random lines with idling on both sides, then a stretch without idling.
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) send_random_line();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    while (bytes_sent < RANDOM_BYTES + CALM_BYTES) send_random_line();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
